// ----- design/jiba_pkg.sv -----
// jiba_pkg: shared types and constants for the jet image binning accumulator
// no dependencies; imported by jet_image_binning_accumulator
package jiba_pkg;

  localparam int GRID_DEFAULT = 33;

  localparam int OFF_W   = 17;
  localparam int HALF_W  = 16;
  localparam int PT_W    = 20;
  localparam int BIN_W   = 6;
  localparam int SUM_W   = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W = 4;

  // window reset is 0.4 in units of 2^-16
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd26214;

  localparam logic [CFG_IDX_W-1:0] REG_ETA_HALF = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_HALF = 4'd1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [SUM_W-1:0]   charged_pt;
    logic [SUM_W-1:0]   neutral_pt;
    logic [COUNT_W-1:0] charged_cnt;
  } pixel_t;

endpackage

// ----- design/jet_image_binning_accumulator.sv -----
// jet_image_binning_accumulator: three-channel jet image with a shared floor divider
// depends on jiba_pkg
//
// Input channel (in_valid / in_stall): one beat is an add (opcode 0) or a read-and-clear
// (opcode 1). Output channel (out_valid / out_stall): one beat per input beat, in order.
// Config: cfg_write with cfg_index 0 (eta half window) or 1 (phi half window) and cfg_data.
// An add bins both offsets through one restoring divider, eta first then phi, one quotient
// bit per cycle; a rejected offset cuts an add short. A read goes through the store read
// step, or straight to the final step when it falls outside the grid.
// The pixel store is a single-port memory of GRID*GRID words; each item does at most one
// read and at most one write of its pixel.
// The block takes one item at a time: in_stall is high from accept until the result is
// loaded into the output register. A new item is taken while that result waits.
// If out_stall holds a previous result, the block waits at its final step with the
// store untouched until the output register frees.
// After reset a clearing pass zeroes every word of the store with in_stall high;
// config writes are taken during it. Windows reset to 0.4.
module jet_image_binning_accumulator #(
  parameter int GRID = jiba_pkg::GRID_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [jiba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jiba_pkg::HALF_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic [jiba_pkg::OFF_W-1:0]      delta_eta,
  input  logic [jiba_pkg::OFF_W-1:0]      delta_phi,
  input  logic [jiba_pkg::PT_W-1:0]       particle_pt,
  input  logic                            is_charged,
  input  logic [jiba_pkg::BIN_W-1:0]      read_col,
  input  logic [jiba_pkg::BIN_W-1:0]      read_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            in_range,
  output logic [jiba_pkg::BIN_W-1:0]      bin_col,
  output logic [jiba_pkg::BIN_W-1:0]      bin_row,
  output logic [jiba_pkg::SUM_W-1:0]      charged_pt_sum,
  output logic [jiba_pkg::SUM_W-1:0]      neutral_pt_sum,
  output logic [jiba_pkg::COUNT_W-1:0]    charged_count
);
  import jiba_pkg::*;

  localparam int CELLS = GRID * GRID;
  localparam int AW    = $clog2(CELLS);
  localparam int QW    = $clog2(GRID);
  localparam int CW    = $clog2(QW + 1);
  localparam int NW    = OFF_W + QW;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOAD, S_DIV, S_RD, S_UPD} state_t;

  state_t state;

  logic [HALF_W-1:0] eta_half;
  logic [HALF_W-1:0] phi_half;

  // latched item
  logic              op;
  logic [OFF_W-1:0]  d_eta;
  logic [OFF_W-1:0]  d_phi;
  logic [PT_W-1:0]   pt;
  logic              chg;
  logic              ok;
  logic              axis;
  logic [QW-1:0]     col;
  logic [QW-1:0]     row;
  logic [AW-1:0]     clr_addr;

  // shared divider
  logic [NW-1:0]     dv_rem;
  logic [NW-1:0]     dv_div;
  logic [QW-1:0]     dv_quo;
  logic [CW-1:0]     dv_cnt;

  // memory
  pixel_t            mem [CELLS];
  pixel_t            rd_data;
  pixel_t            wr_data;
  pixel_t            upd;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     pix_addr;

  // divider load
  logic [OFF_W-1:0]  ld_off;
  logic [HALF_W-1:0] ld_half;
  logic [OFF_W:0]    ld_sum;
  logic              ld_reject;
  logic [NW-1:0]     ld_num;
  logic [NW-1:0]     ld_div;

  // divider step
  logic              st_ge;
  logic [QW-1:0]     q_fin;

  logic              can_emit;
  logic [SUM_W:0]    add_c;
  logic [SUM_W:0]    add_n;
  logic [QW+BIN_W-1:0] col_ext;
  logic [QW+BIN_W-1:0] row_ext;
  logic [QW+BIN_W-1:0] rcol_ext;
  logic [QW+BIN_W-1:0] rrow_ext;
  logic              read_ok;

  assign in_stall = (state != S_IDLE);
  assign can_emit = !out_valid || !out_stall;

  always_comb begin
    ld_off    = axis ? d_phi : d_eta;
    ld_half   = axis ? phi_half : eta_half;
    ld_sum    = {ld_off[OFF_W-1], ld_off} + {2'b00, ld_half};
    // below the lower edge, or at or beyond the upper edge
    ld_reject = ld_sum[OFF_W] || ($signed(ld_off) >= $signed({1'b0, ld_half}));
    ld_num    = NW'(ld_sum[OFF_W-1:0]) * NW'(GRID);
    ld_div    = NW'({ld_half, 1'b0}) << (QW - 1);
  end

  always_comb begin
    st_ge = (dv_rem >= dv_div);
    q_fin = (dv_quo << 1) | QW'(st_ge);
  end

  assign pix_addr = AW'(row) * AW'(GRID) + AW'(col);

  always_comb begin
    add_c = {1'b0, rd_data.charged_pt} + {{(SUM_W + 1 - PT_W){1'b0}}, pt};
    add_n = {1'b0, rd_data.neutral_pt} + {{(SUM_W + 1 - PT_W){1'b0}}, pt};
    upd   = rd_data;
    if (op == OP_READ) begin
      upd = '0;
    end else if (chg) begin
      upd.charged_pt  = add_c[SUM_W] ? '1 : add_c[SUM_W-1:0];
      upd.charged_cnt = (rd_data.charged_cnt == '1) ? rd_data.charged_cnt
                                                     : rd_data.charged_cnt + 1'b1;
    end else begin
      upd.neutral_pt  = add_n[SUM_W] ? '1 : add_n[SUM_W-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    wr_data   = upd;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      wr_data   = '0;
    end else if (state == S_UPD && ok && can_emit) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_data;
    end
    if (state == S_RD) begin
      rd_data <= mem[pix_addr];
    end
  end

  assign col_ext  = {{BIN_W{1'b0}}, col};
  assign row_ext  = {{BIN_W{1'b0}}, row};
  assign rcol_ext = {{QW{1'b0}}, read_col};
  assign rrow_ext = {{QW{1'b0}}, read_row};
  assign read_ok  = (int'(read_col) < GRID) && (int'(read_row) < GRID);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      eta_half  <= HALF_RESET;
      phi_half  <= HALF_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ETA_HALF: eta_half <= cfg_data;
          REG_PHI_HALF: phi_half <= cfg_data;
          default: ;
        endcase
      end
      // the final step reloads the output register itself
      if (out_valid && !out_stall && state != S_UPD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            d_eta <= delta_eta;
            d_phi <= delta_phi;
            pt    <= particle_pt;
            chg   <= is_charged;
            axis  <= 1'b0;
            if (opcode == OP_READ) begin
              ok    <= read_ok;
              col   <= rcol_ext[QW-1:0];
              row   <= rrow_ext[QW-1:0];
              state <= read_ok ? S_RD : S_UPD;
            end else begin
              ok    <= 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (ld_reject) begin
            ok    <= 1'b0;
            state <= S_UPD;
          end else begin
            dv_rem <= ld_num;
            dv_div <= ld_div;
            dv_quo <= '0;
            dv_cnt <= CW'(QW - 1);
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (st_ge) begin
            dv_rem <= dv_rem - dv_div;
          end
          dv_div <= dv_div >> 1;
          dv_quo <= q_fin;
          dv_cnt <= dv_cnt - 1'b1;
          if (dv_cnt == '0) begin
            if (!axis) begin
              col   <= q_fin;
              axis  <= 1'b1;
              state <= S_LOAD;
            end else begin
              row   <= q_fin;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (can_emit) begin
            out_valid <= 1'b1;
            in_range  <= ok;
            if (ok) begin
              bin_col        <= col_ext[BIN_W-1:0];
              bin_row        <= row_ext[BIN_W-1:0];
              // reads return the pixel before its clear, adds the pixel after the add
              charged_pt_sum <= (op == OP_READ) ? rd_data.charged_pt  : upd.charged_pt;
              neutral_pt_sum <= (op == OP_READ) ? rd_data.neutral_pt  : upd.neutral_pt;
              charged_count  <= (op == OP_READ) ? rd_data.charged_cnt : upd.charged_cnt;
            end else begin
              bin_col        <= '0;
              bin_row        <= '0;
              charged_pt_sum <= '0;
              neutral_pt_sum <= '0;
              charged_count  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && in_stall)
    else $error("output or input open straight after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> charged_pt_sum == '0 && neutral_pt_sum == '0 &&
                               charged_count == '0 && bin_col == '0 && bin_row == '0)
    else $error("rejected beat carries non-zero fields");

  a_bin_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && ok |-> int'(col) < GRID && int'(row) < GRID)
    else $error("binned pixel outside grid");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE && state != S_CLEAR)
    else $error("accepted beat not taken into work");

  a_emit_on_free: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && out_valid && out_stall |=> state == S_UPD && out_valid)
    else $error("result dropped while output held");

endmodule

// ----- tb/sv/jet_image_binning_accumulator_test.sv -----
// jet_image_binning_accumulator_test: self-checking bench for the jet image accumulator
// holds a pixel-image scoreboard class and the tasks that drive both channels
// depends on jiba_pkg and jet_image_binning_accumulator
module jet_image_binning_accumulator_test;
  import jiba_pkg::*;

  localparam int GRID = GRID_DEFAULT;
  localparam int CELLS = GRID * GRID;
  localparam int PT_MAX = (1 << PT_W) - 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HEAVY_ADDS = 6;

  typedef struct packed {
    logic               opcode;
    logic [OFF_W-1:0]   delta_eta;
    logic [OFF_W-1:0]   delta_phi;
    logic [PT_W-1:0]    pt;
    logic               charged;
    logic [BIN_W-1:0]   col;
    logic [BIN_W-1:0]   row;
  } jet_beat_t;

  typedef struct packed {
    logic               in_range;
    logic [BIN_W-1:0]   col;
    logic [BIN_W-1:0]   row;
    logic [SUM_W-1:0]   charged_pt;
    logic [SUM_W-1:0]   neutral_pt;
    logic [COUNT_W-1:0] count;
  } pixel_result_t;

  class jet_image_scoreboard;
    bit [SUM_W-1:0]   charged_img [CELLS];
    bit [SUM_W-1:0]   neutral_img [CELLS];
    bit [COUNT_W-1:0] count_img [CELLS];
    bit [HALF_W-1:0]  eta_half = HALF_RESET;
    bit [HALF_W-1:0]  phi_half = HALF_RESET;
    pixel_result_t    pixels_due [$];
    int unsigned      mismatches;
    int unsigned      checked;

    function void set_window(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] data);
      if (idx == REG_ETA_HALF) eta_half = data;
      else if (idx == REG_PHI_HALF) phi_half = data;
    endfunction

    // floor((off + half) * GRID / (2 * half)), rejected outside [0, GRID)
    function bit floor_bin(logic [OFF_W-1:0] off, bit [HALF_W-1:0] half,
                           output bit [BIN_W-1:0] slot);
      longint num;
      longint den;
      longint q;
      slot = '0;
      if (half == 0) return 1'b0;
      num = (longint'($signed(off)) + longint'(half)) * GRID;
      den = 2 * longint'(half);
      if (num < 0) return 1'b0;
      q = num / den;
      if (q >= GRID) return 1'b0;
      slot = q[BIN_W-1:0];
      return 1'b1;
    endfunction

    function pixel_result_t note_beat(jet_beat_t b);
      pixel_result_t r;
      bit [BIN_W-1:0] c;
      bit [BIN_W-1:0] w;
      bit eta_ok;
      bit phi_ok;
      int idx;
      logic [SUM_W:0] s;
      r = '0;
      if (b.opcode == OP_ADD) begin
        eta_ok = floor_bin(b.delta_eta, eta_half, c);
        phi_ok = floor_bin(b.delta_phi, phi_half, w);
        if (eta_ok && phi_ok) begin
          idx = int'(w) * GRID + int'(c);
          if (b.charged) begin
            s = {1'b0, charged_img[idx]} + (SUM_W+1)'(b.pt);
            charged_img[idx] = s[SUM_W] ? '1 : s[SUM_W-1:0];
            if (count_img[idx] != '1) count_img[idx] = count_img[idx] + 1'b1;
          end else begin
            s = {1'b0, neutral_img[idx]} + (SUM_W+1)'(b.pt);
            neutral_img[idx] = s[SUM_W] ? '1 : s[SUM_W-1:0];
          end
          r = '{1'b1, c, w, charged_img[idx], neutral_img[idx], count_img[idx]};
        end
      end else if (b.col < GRID && b.row < GRID) begin
        idx = int'(b.row) * GRID + int'(b.col);
        r = '{1'b1, b.col, b.row, charged_img[idx], neutral_img[idx], count_img[idx]};
        charged_img[idx] = '0;
        neutral_img[idx] = '0;
        count_img[idx] = '0;
      end
      pixels_due.insert(pixels_due.size(), r);
      return r;
    endfunction

    function void flag(string why, pixel_result_t want, pixel_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: want in_range=%0d col=%0d row=%0d chg=%0d neu=%0d cnt=%0d", why,
                 want.in_range, want.col, want.row, want.charged_pt, want.neutral_pt,
                 want.count);
        $display("  got in_range=%0d col=%0d row=%0d chg=%0d neu=%0d cnt=%0d",
                 got.in_range, got.col, got.row, got.charged_pt, got.neutral_pt, got.count);
      end
    endfunction

    function void check_beat(pixel_result_t got);
      pixel_result_t want;
      if (pixels_due.size() == 0) begin
        flag("result beat with nothing outstanding", '0, got);
        return;
      end
      want = pixels_due.pop_front();
      if (got.in_range !== want.in_range || got.col !== want.col || got.row !== want.row ||
          got.charged_pt !== want.charged_pt || got.neutral_pt !== want.neutral_pt ||
          got.count !== want.count)
        flag("pixel result mismatch", want, got);
      else
        checked++;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [HALF_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_ADD;
  logic [OFF_W-1:0] delta_eta = '0;
  logic [OFF_W-1:0] delta_phi = '0;
  logic [PT_W-1:0] particle_pt = '0;
  logic is_charged = 1'b0;
  logic [BIN_W-1:0] read_col = '0;
  logic [BIN_W-1:0] read_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic in_range;
  logic [BIN_W-1:0] bin_col;
  logic [BIN_W-1:0] bin_row;
  logic [SUM_W-1:0] charged_pt_sum;
  logic [SUM_W-1:0] neutral_pt_sum;
  logic [COUNT_W-1:0] charged_count;

  jet_image_scoreboard sb = new();
  bit idle_on = 1'b1;
  int hold_left = 0;
  longint cycle_count = 0;
  int unsigned adds_sent, reads_sent, binned, window_writes;
  bit [2*BIN_W-1:0] hot_pixels [$];

  jet_image_binning_accumulator #(.GRID(GRID)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .delta_eta(delta_eta), .delta_phi(delta_phi),
    .particle_pt(particle_pt), .is_charged(is_charged),
    .read_col(read_col), .read_row(read_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .in_range(in_range), .bin_col(bin_col), .bin_row(bin_row),
    .charged_pt_sum(charged_pt_sum), .neutral_pt_sum(neutral_pt_sum),
    .charged_count(charged_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check each accepted beat, then, while idle_on is set, hold stall for a random spell
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_beat({in_range, bin_col, bin_row, charged_pt_sum, neutral_pt_sum,
                       charged_count});
        hold_left = idle_on ? $urandom_range(0, 9) : 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  function automatic jet_beat_t noise_beat();
    jet_beat_t b;
    b.opcode = 1'($urandom_range(0, 1));
    b.delta_eta = OFF_W'($urandom);
    b.delta_phi = OFF_W'($urandom);
    b.pt = PT_W'($urandom);
    b.charged = 1'($urandom_range(0, 1));
    b.col = BIN_W'($urandom);
    b.row = BIN_W'($urandom);
    return b;
  endfunction

  function automatic jet_beat_t add_beat(int eta, int phi, int pt, bit charged);
    jet_beat_t b;
    b = noise_beat();
    b.opcode = OP_ADD;
    b.delta_eta = OFF_W'(eta);
    b.delta_phi = OFF_W'(phi);
    b.pt = PT_W'(pt);
    b.charged = charged;
    return b;
  endfunction

  function automatic jet_beat_t read_beat(int col, int row);
    jet_beat_t b;
    b = noise_beat();
    b.opcode = OP_READ;
    b.col = BIN_W'(col);
    b.row = BIN_W'(row);
    return b;
  endfunction

  // offset inside the window (any offset when the window is zero), half the time crowded near the jet axis
  function automatic int window_offset(int unsigned half);
    if (half == 0) return int'($urandom_range(0, 131071)) - 65536;
    if ($urandom_range(0, 1))
      return int'($urandom_range(0, half / 4)) - int'(half / 8);
    return int'($urandom_range(0, 2 * half - 1)) - int'(half);
  endfunction

  function automatic jet_beat_t random_beat();
    jet_beat_t b;
    int unsigned pick;
    int unsigned sel;
    b = noise_beat();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      b.opcode = OP_ADD;
      b.delta_eta = OFF_W'(window_offset(sb.eta_half));
      b.delta_phi = OFF_W'(window_offset(sb.phi_half));
      sel = $urandom_range(0, 9);
      if (sel == 0) b.pt = '0;
      else if (sel == 1) b.pt = '1;
    end else if (pick < 85) begin
      b.opcode = OP_READ;
      if (hot_pixels.size() != 0 && $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, hot_pixels.size() - 1);
        {b.col, b.row} = hot_pixels[sel];
      end else begin
        b.col = BIN_W'($urandom_range(0, GRID - 1));
        b.row = BIN_W'($urandom_range(0, GRID - 1));
      end
    end
    return b;
  endfunction

  task automatic send_beat(jet_beat_t b);
    int unsigned gap;
    pixel_result_t r;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= b.opcode;
    delta_eta <= b.delta_eta;
    delta_phi <= b.delta_phi;
    particle_pt <= b.pt;
    is_charged <= b.charged;
    read_col <= b.col;
    read_row <= b.row;
    do @(posedge clk); while (in_stall);
    r = sb.note_beat(b);
    if (b.opcode == OP_ADD) begin
      adds_sent++;
      if (r.in_range) begin
        binned++;
        hot_pixels.insert(hot_pixels.size(), {r.col, r.row});
        if (hot_pixels.size() > 16) void'(hot_pixels.pop_front());
      end
    end else begin
      reads_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_window(idx, data);
    window_writes++;
    @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == n / 2) drain();
      send_beat(random_beat());
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset windows of 0.4: centre, both edges, just outside, full-scale offsets
    send_beat(add_beat(0, 0, 100, 1'b1));
    send_beat(add_beat(0, 0, PT_MAX, 1'b0));
    send_beat(add_beat(0, 0, 0, 1'b1));
    send_beat(add_beat(-26214, -26214, PT_MAX, 1'b1));
    send_beat(add_beat(26213, 26213, 7, 1'b0));
    send_beat(add_beat(-26215, 0, 5, 1'b1));
    send_beat(add_beat(0, 26214, 5, 1'b1));
    send_beat(add_beat(-65536, -65536, 5, 1'b0));
    send_beat(add_beat(65535, 65535, 5, 1'b1));
    send_beat(read_beat(16, 16));
    send_beat(read_beat(16, 16));
    send_beat(read_beat(0, 0));
    send_beat(read_beat(32, 32));
    send_beat(read_beat(33, 0));
    send_beat(read_beat(0, 33));
    send_beat(read_beat(63, 63));
    send_beat(read_beat(32, 63));
    drain();
    run_random(70);

    // narrowest eta window against widest phi window
    write_reg(REG_ETA_HALF, 16'd1);
    write_reg(REG_PHI_HALF, 16'hffff);
    send_beat(add_beat(-1, -65535, 11, 1'b1));
    send_beat(add_beat(0, 65534, 12, 1'b0));
    send_beat(add_beat(1, 0, 13, 1'b1));
    send_beat(add_beat(-2, 65535, 14, 1'b1));
    run_random(70);

    write_reg(REG_ETA_HALF, 16'hffff);
    write_reg(REG_PHI_HALF, 16'd1);
    run_random(70);

    // zero eta window rejects every add; writes past the last register do nothing
    write_reg(REG_ETA_HALF, 16'd0);
    write_reg(REG_PHI_HALF, HALF_W'($urandom_range(1, 65535)));
    write_reg(4'd15, 16'd0);
    write_reg(CFG_IDX_W'($urandom_range(2, 14)), HALF_W'($urandom));
    for (int i = 0; i < 6; i++) send_beat(add_beat(0, 0, 9, i[0]));
    run_random(20);

    write_reg(REG_ETA_HALF, HALF_W'($urandom_range(1, 65535)));
    write_reg(REG_PHI_HALF, HALF_W'($urandom_range(1, 65535)));
    run_random(70);

    // pile full-scale momentum onto two corner pixels, back to back
    write_reg(REG_ETA_HALF, HALF_RESET);
    write_reg(REG_PHI_HALF, HALF_RESET);
    idle_on = 1'b0;
    for (int i = 0; i < HEAVY_ADDS; i++) send_beat(add_beat(-26214, -26214, PT_MAX, 1'b1));
    for (int i = 0; i < HEAVY_ADDS; i++) send_beat(add_beat(26213, 26213, PT_MAX, 1'b0));
    send_beat(read_beat(0, 0));
    send_beat(read_beat(32, 32));
    drain();

    write_reg(REG_ETA_HALF, HALF_W'($urandom_range(1, 2000)));
    write_reg(REG_PHI_HALF, HALF_W'($urandom_range(1, 65535)));
    run_random(70);

    $display("%0d adds (%0d binned, %0d outside window), %0d reads, %0d register writes",
             adds_sent, binned, adds_sent - binned, reads_sent, window_writes);
    $display("%0d results matched, %0d mismatches, %0d still outstanding",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- jet_image_binning_accumulator.f -----
design/jiba_pkg.sv
design/jet_image_binning_accumulator.sv
tb/sv/jet_image_binning_accumulator_test.sv
